>>> rtl/core/lcc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the card number classifier.
// Used by lcc_digit_cell, lcc_scan and luhn_card_classifier.
package lcc_pkg;

   localparam int CARD_W  = 63;  // width of the binary card number
   localparam int COUNT_W = 5;   // width of the digit count
   localparam int CLASS_W = 2;   // width of the class code
   localparam int BCD_W   = 4;   // one decimal digit

   localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_PAIR34 = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_LEAD4  = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_PAIR5X = 2'd3;

   // Control lines shared by every digit cell of the chain.
   typedef struct packed {
      logic clear;   // zero the digit
      logic dabble;  // shift one binary bit in from the lower neighbor
      logic drain;   // take the digit of the upper neighbor
   } lcc_cell_ctrl_type;

   typedef struct packed {
      logic [CLASS_W-1:0] card_class;
      logic               luhn_ok;
      logic [COUNT_W-1:0] digit_count;
   } lcc_result_type;

   // Digit sum of twice a decimal digit.
   function automatic logic [BCD_W-1:0] luhn_double(input logic [BCD_W-1:0] d);
      logic [BCD_W:0] twice;
      twice = {d, 1'b0};
      if (d >= BCD_W'(5)) begin
         luhn_double = BCD_W'(twice - (BCD_W+1)'(9));
      end else begin
         luhn_double = twice[BCD_W-1:0];
      end
   endfunction

endpackage

>>> rtl/core/lcc_digit_cell.sv
`timescale 1ns / 1ps
// One decimal digit cell of the binary to BCD chain.
// Depends on lcc_pkg for the control struct and digit width.
module lcc_digit_cell (
   input  logic                       clock,
   input  lcc_pkg::lcc_cell_ctrl_type ctrl,
   input  logic                       bit_in,
   output logic                       carry_out,
   input  logic [lcc_pkg::BCD_W-1:0]  upper_digit,
   output logic [lcc_pkg::BCD_W-1:0]  digit_out
);
   import lcc_pkg::*;

   logic [BCD_W-1:0] digit_ff;
   logic [BCD_W-1:0] digit_in;
   logic [BCD_W-1:0] adjusted;

   // Add three before the shift so that a digit of five or more carries out.
   assign adjusted  = (digit_ff >= BCD_W'(5)) ? digit_ff + BCD_W'(3) : digit_ff;
   assign carry_out = adjusted[BCD_W-1];
   assign digit_out = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.dabble) begin
         digit_in = {adjusted[BCD_W-2:0], bit_in};
      end else if (ctrl.drain) begin
         digit_in = upper_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

>>> rtl/core/lcc_scan.sv
`timescale 1ns / 1ps
// Serial Luhn accumulator, digit counter and prefix classifier.
// Takes one decimal digit per step, least significant first; depends on lcc_pkg.
module lcc_scan (
   input  logic                         clock,
   input  logic                         start,
   input  logic                         step,
   input  logic [lcc_pkg::COUNT_W-1:0]  index,
   input  logic [lcc_pkg::BCD_W-1:0]    digit,
   output lcc_pkg::lcc_result_type      result
);
   import lcc_pkg::*;

   logic [BCD_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [BCD_W-1:0]   prev_ff, prev_in;
   logic [BCD_W-1:0]   top1_ff, top1_in;
   logic [BCD_W-1:0]   top2lo_ff, top2lo_in;
   logic [BCD_W-1:0]   term;
   logic [BCD_W:0]     total;
   logic               len_ok;

   assign term  = index[0] ? luhn_double(digit) : digit;
   assign total = {1'b0, sum_ff} + {1'b0, term};

   always_comb begin
      sum_in    = sum_ff;
      count_in  = count_ff;
      prev_in   = prev_ff;
      top1_in   = top1_ff;
      top2lo_in = top2lo_ff;
      if (start) begin
         sum_in    = '0;
         count_in  = '0;
         prev_in   = '0;
         top1_in   = '0;
         top2lo_in = '0;
      end else if (step) begin
         // The sum is kept modulo ten.
         if (total >= (BCD_W+1)'(10)) begin
            sum_in = BCD_W'(total - (BCD_W+1)'(10));
         end else begin
            sum_in = total[BCD_W-1:0];
         end
         prev_in = digit;
         // A nonzero digit is the most significant one seen so far.
         if (digit != '0) begin
            count_in  = index + COUNT_W'(1);
            top1_in   = digit;
            top2lo_in = prev_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      count_ff  <= count_in;
      prev_ff   <= prev_in;
      top1_ff   <= top1_in;
      top2lo_ff <= top2lo_in;
   end

   assign len_ok = (count_ff >= COUNT_W'(13)) && (count_ff <= COUNT_W'(16));

   always_comb begin
      result.luhn_ok     = (sum_ff == '0);
      result.digit_count = count_ff;
      result.card_class  = CLASS_NONE;
      if (result.luhn_ok && len_ok) begin
         case (count_ff)
            COUNT_W'(15): begin
               if (top1_ff == BCD_W'(3) &&
                   (top2lo_ff == BCD_W'(4) || top2lo_ff == BCD_W'(7))) begin
                  result.card_class = CLASS_PAIR34;
               end
            end
            COUNT_W'(13): begin
               if (top1_ff == BCD_W'(4)) begin
                  result.card_class = CLASS_LEAD4;
               end
            end
            COUNT_W'(16): begin
               if (top1_ff == BCD_W'(4)) begin
                  result.card_class = CLASS_LEAD4;
               end else if (top1_ff == BCD_W'(5) && top2lo_ff >= BCD_W'(1) &&
                            top2lo_ff <= BCD_W'(5)) begin
                  result.card_class = CLASS_PAIR5X;
               end
            end
            default: begin
               result.card_class = CLASS_NONE;
            end
         endcase
      end
   end

endmodule

>>> rtl/core/luhn_card_classifier.sv
`timescale 1ns / 1ps
// Top level of the Luhn card number checker and classifier.
// Depends on lcc_pkg, lcc_digit_cell and lcc_scan.
//
//   port group  direction  beat contents
//   req_*       in         req_card_number
//   rsp_*       out        rsp_card_class, rsp_luhn_ok, rsp_digit_count
//
// A number goes through shift-and-add-three in the digit cells (ST_CONV), then
// its digits are drained into the Luhn scanner (ST_SCAN), then the result
// register is loaded in ST_FINISH once it is free to take a new result.
// Reset is synchronous and clears the control state only.
// The result register lets a new beat be accepted while a result is stalled;
// a finished result waits in place until the previous one is taken.
module luhn_card_classifier #(
   parameter int MAX_DIGITS = 19
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lcc_pkg::CARD_W-1:0]    req_card_number,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lcc_pkg::CLASS_W-1:0]   rsp_card_class,
   output logic                          rsp_luhn_ok,
   output logic [lcc_pkg::COUNT_W-1:0]   rsp_digit_count
);
   import lcc_pkg::*;

   localparam int CNT_W = $clog2(CARD_W);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CONV   = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CARD_W-1:0] shift_ff, shift_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lcc_result_type    rsp_ff, rsp_in;

   logic              req_take;
   logic              rsp_free;
   lcc_cell_ctrl_type ctrl;
   lcc_result_type    scan_result;
   logic              scan_start;
   logic              scan_step;

   logic [MAX_DIGITS:0]   bit_chain;
   logic [BCD_W-1:0]      digit_chain [0:MAX_DIGITS];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign ctrl.clear  = req_take;
   assign ctrl.dabble = (state_ff == ST_CONV);
   assign ctrl.drain  = (state_ff == ST_SCAN);

   assign scan_start = req_take;
   assign scan_step  = (state_ff == ST_SCAN);

   // The binary number enters the chain most significant bit first.
   assign bit_chain[0]            = shift_ff[CARD_W-1];
   assign digit_chain[MAX_DIGITS] = '0;

   for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
      lcc_digit_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .bit_in      (bit_chain[k]),
         .carry_out   (bit_chain[k+1]),
         .upper_digit (digit_chain[k+1]),
         .digit_out   (digit_chain[k])
      );
   end

   lcc_scan u_scan (
      .clock  (clock),
      .start  (scan_start),
      .step   (scan_step),
      .index  (cnt_ff[COUNT_W-1:0]),
      .digit  (digit_chain[0]),
      .result (scan_result)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               shift_in = req_card_number;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            shift_in = {shift_ff[CARD_W-2:0], 1'b0};
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CARD_W - 1)) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MAX_DIGITS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_in       = scan_result;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_card_class  = rsp_ff.card_class;
   assign rsp_luhn_ok     = rsp_ff.luhn_ok;
   assign rsp_digit_count = rsp_ff.digit_count;

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_CONV) && (cnt_ff == '0))
      else $error("accepted beat did not start the conversion");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_count <= COUNT_W'(MAX_DIGITS)))
      else $error("digit count beyond the chain length");

   a_class_needs_luhn: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_card_class != CLASS_NONE) |->
         (rsp_luhn_ok && rsp_digit_count >= COUNT_W'(13) &&
          rsp_digit_count <= COUNT_W'(16)))
      else $error("class given to a number that fails the check or length");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_free) |=> rsp_valid && (state_ff == ST_IDLE))
      else $error("finished result was not loaded");

endmodule
